// File: hw/rtl/swaff_pkg.sv
// shared types, codes and defaults for the affine-gap local alignment block
package swaff_pkg;

  parameter int MAX_QUERY_DEF  = 64;
  parameter int SCORE_BITS_DEF = 16;

  // position field is six bits, so no row is ever longer than this
  parameter int ROW_CAP     = 64;
  parameter int POS_BITS    = 6;
  parameter int CAP_BITS    = 15;
  parameter int OUT_CAP     = 32767;
  parameter int QUEUE_DEPTH = 2;

  // request codes on the req_type field
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ROW  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MATCH    = 2'd0;
  localparam logic [1:0] CFG_MISMATCH = 2'd1;
  localparam logic [1:0] CFG_OPEN     = 2'd2;
  localparam logic [1:0] CFG_EXTEND   = 2'd3;

  typedef enum logic {
    OP_LOAD,
    OP_ROW
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [1:0]          base;
    logic [POS_BITS-1:0] pos;
    logic                new_aln;
  } item_t;

  typedef struct packed {
    logic [6:0] match;
    logic [7:0] mismatch;
    logic [7:0] open_cost;
    logic [7:0] extend_cost;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } bk_state_t;

endpackage

// File: hw/rtl/swaff_front.sv
// front end: takes request words, drops out-of-range loads, queues the rest
module swaff_front #(
  parameter int MAX_QUERY = swaff_pkg::MAX_QUERY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [1:0]                    base,
  input  logic [swaff_pkg::POS_BITS-1:0] position,
  input  logic                          new_alignment,
  output logic                          q_valid,
  output swaff_pkg::item_t              q_item,
  input  logic                          q_pop
);

  localparam int DEPTH = (MAX_QUERY < swaff_pkg::ROW_CAP) ? MAX_QUERY : swaff_pkg::ROW_CAP;
  localparam int QD    = swaff_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(QD);
  localparam int CNTW  = $clog2(QD + 1);

  swaff_pkg::item_t         slots [QD];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic [CNTW-1:0]          count;
  swaff_pkg::item_t         item;
  logic                     keep;
  logic                     push;

  always_comb begin
    item.op      = (req_type == swaff_pkg::REQ_ROW) ? swaff_pkg::OP_ROW : swaff_pkg::OP_LOAD;
    item.base    = base;
    item.pos     = position;
    item.new_aln = new_alignment;
    // a load beyond the query store is dropped here
    keep = (req_type == swaff_pkg::REQ_ROW) ||
           ({1'b0, position} < (swaff_pkg::POS_BITS + 1)'(DEPTH));
  end

  assign in_stall = (count == CNTW'(QD));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !q_pop) begin
        count <= count + CNTW'(1);
      end else if (q_pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/swaff_back.sv
// back end: query store, row store and the per-cell score pipeline
module swaff_back #(
  parameter int MAX_QUERY  = swaff_pkg::MAX_QUERY_DEF,
  parameter int SCORE_BITS = swaff_pkg::SCORE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swaff_pkg::cfg_t                cfg,
  input  logic                           q_valid,
  input  swaff_pkg::item_t               q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [swaff_pkg::POS_BITS-1:0] query_index,
  output logic [swaff_pkg::CAP_BITS-1:0] cell_score,
  output logic [2:0]                     direction_code,
  output logic [swaff_pkg::CAP_BITS-1:0] best_score,
  output logic                           row_last
);

  localparam int DEPTH = (MAX_QUERY < swaff_pkg::ROW_CAP) ? MAX_QUERY : swaff_pkg::ROW_CAP;
  localparam int IW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int W     = SCORE_BITS + 2;
  localparam int CW    = (W > swaff_pkg::CAP_BITS + 2) ? W : swaff_pkg::CAP_BITS + 2;
  localparam int PB    = swaff_pkg::POS_BITS;
  localparam int OB    = swaff_pkg::CAP_BITS;

  localparam logic signed [W-1:0] SAT_HI = W'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
  localparam logic signed [W-1:0] SAT_LO = W'(-(64'sd1 <<< (SCORE_BITS - 1)));
  localparam logic signed [CW-1:0] CAP   = CW'(swaff_pkg::OUT_CAP);

  typedef logic signed [SCORE_BITS-1:0] score_t;

  function automatic score_t sat(input logic signed [W-1:0] v);
    score_t r;
    if (v > SAT_HI) begin
      r = score_t'(SAT_HI[SCORE_BITS-1:0]);
    end else if (v < SAT_LO) begin
      r = score_t'(SAT_LO[SCORE_BITS-1:0]);
    end else begin
      r = score_t'(v[SCORE_BITS-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] wx(input score_t s);
    return W'(s);
  endfunction

  function automatic score_t smax(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

  // settings widened to the internal sum width
  logic signed [W-1:0] match_w, mism_w, open_w, ext_w;
  assign match_w = W'({1'b0, cfg.match});
  assign mism_w  = W'($signed(cfg.mismatch));
  assign open_w  = W'({1'b0, cfg.open_cost});
  assign ext_w   = W'({1'b0, cfg.extend_cost});

  // storage
  logic [1:0]         qmem [DEPTH];
  score_t             hmem [DEPTH];
  score_t             fmem [DEPTH];
  logic [DEPTH-1:0]   row_vld;
  logic [LW-1:0]      query_length;
  logic [OB-1:0]      best_r;

  // sequencer
  swaff_pkg::bk_state_t state, state_next;
  logic [IW-1:0]      cnt;
  logic [LW-1:0]      row_len;
  logic [1:0]         row_base;
  logic               adv;
  logic               issue;
  logic               at_end;
  logic               load_we;
  logic               row_start;
  logic               clr;

  // stage 1: read data of one cell
  logic               s1_valid, s1_last, s1_first, s1_vld;
  logic [IW-1:0]      s1_j;
  logic [1:0]         s1_q;
  score_t             s1_hup, s1_fup;
  score_t             hdiag_r;

  // stage 2: diagonal and up-gap terms
  logic               s2_valid, s2_last, s2_first;
  logic [IW-1:0]      s2_j;
  score_t             s2_d, s2_f;
  score_t             e_r, hleft_r;

  logic               wr_en;

  // stage 1 datapath
  score_t              hup, fup, hdiag, d1, f1;
  logic signed [W-1:0] subst;

  // stage 2 datapath
  score_t               e_prev, h_prev, e2, mde, mfz, h;
  logic [2:0]           dir;
  logic signed [CW-1:0] h_c;
  logic [OB-1:0]        hout, best_next;

  assign adv    = !out_valid || !out_stall;
  assign at_end = (cnt == IW'(row_len - LW'(1)));
  assign wr_en  = adv && s2_valid;

  always_comb begin
    q_pop     = (state == swaff_pkg::BK_IDLE) && q_valid;
    load_we   = q_pop && (q_item.op == swaff_pkg::OP_LOAD);
    row_start = q_pop && (q_item.op == swaff_pkg::OP_ROW);
    clr       = row_start && q_item.new_aln;
    issue     = (state == swaff_pkg::BK_RUN) && adv;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swaff_pkg::BK_IDLE: begin
        if (row_start && (query_length != '0)) begin
          state_next = swaff_pkg::BK_RUN;
        end
      end
      swaff_pkg::BK_RUN: begin
        if (issue && at_end) begin
          state_next = swaff_pkg::BK_DRAIN;
        end
      end
      swaff_pkg::BK_DRAIN: begin
        // row store writes of this row land before the next row reads
        if (!s1_valid && !s2_valid) begin
          state_next = swaff_pkg::BK_IDLE;
        end
      end
      default: state_next = swaff_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swaff_pkg::BK_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (row_start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_start) begin
      row_len  <= query_length;
      row_base <= q_item.base;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (load_we) begin
      qmem[q_item.pos[IW-1:0]] <= q_item.base;
    end
    if (wr_en) begin
      hmem[s2_j] <= h;
      fmem[s2_j] <= s2_f;
    end
    if (adv) begin
      s1_q   <= qmem[cnt];
      s1_hup <= hmem[cnt];
      s1_fup <= fmem[cnt];
      s1_vld <= row_vld[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld      <= '0;
      query_length <= '0;
      best_r       <= '0;
    end else begin
      if (load_we) begin
        query_length <= LW'(q_item.pos[IW-1:0]) + LW'(1);
      end
      if (clr) begin
        row_vld <= '0;
        best_r  <= '0;
      end else if (wr_en) begin
        row_vld[s2_j] <= 1'b1;
        best_r        <= best_next;
      end
    end
  end

  always_comb begin
    hup   = s1_vld ? s1_hup : '0;
    fup   = s1_vld ? s1_fup : '0;
    hdiag = s1_first ? '0 : hdiag_r;
    subst = (s1_q == row_base) ? match_w : mism_w;
    d1    = sat(wx(hdiag) + subst);
    f1    = smax(sat(wx(fup) - ext_w), sat(wx(hup) - open_w));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_j     <= cnt;
      s1_last  <= at_end;
      s1_first <= (cnt == '0);
      s2_j     <= s1_j;
      s2_last  <= s1_last;
      s2_first <= s1_first;
      s2_d     <= d1;
      s2_f     <= f1;
      if (s1_valid) begin
        hdiag_r <= hup;
      end
    end
  end

  always_comb begin
    e_prev    = s2_first ? '0 : e_r;
    h_prev    = s2_first ? '0 : hleft_r;
    e2        = smax(sat(wx(e_prev) - ext_w), sat(wx(h_prev) - open_w));
    mde       = smax(s2_d, e2);
    mfz       = smax(s2_f, '0);
    h         = smax(mde, mfz);
    dir       = {s2_d >= e2, !s2_f[SCORE_BITS-1], mde >= mfz};
    h_c       = CW'(h);
    hout      = (h_c > CAP) ? OB'(swaff_pkg::OUT_CAP) : h_c[OB-1:0];
    best_next = (hout > best_r) ? hout : best_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      e_r            <= e2;
      hleft_r        <= h;
      query_index    <= PB'(s2_j);
      cell_score     <= hout;
      direction_code <= dir;
      best_score     <= best_next;
      row_last       <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

`ifndef SYNTH
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == swaff_pkg::BK_IDLE) |-> (!s1_valid && !s2_valid))
    else $error("cell pipeline busy while sequencer idle");

  a_cells_in_order: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |-> (s1_j == s2_j + IW'(1)))
    else $error("cells in flight are not consecutive");

  a_best_rises: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (best_r >= $past(best_r)))
    else $error("best score fell within an alignment");

  a_cell_below_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cell_score <= best_score))
    else $error("cell score above running best");

  a_no_issue_past_row: assert property (@(posedge clk) disable iff (rst)
    (state == swaff_pkg::BK_RUN) |-> ((LW'(cnt) < row_len) && (row_len != '0)))
    else $error("cell index beyond row length");
`endif

endmodule

// File: hw/rtl/smith_waterman_affine_with_direction.sv
// top level: settings registers, request front end and cell back end
//
//  channel  direction  handshake          word
//  in       to block   in_valid/in_stall  req_type, base, position, new_alignment
//  out      from block out_valid/out_stall query_index, cell_score, direction_code,
//                                          best_score, row_last
//  cfg      to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  a load word is written to the query store when it is popped; a row word for
//  a query of n > 0 bases is popped, then runs one cell per cycle unless the
//  output stalls, then drains the two-stage cell pipeline so the row store writes land first
//  a two-word queue sits between front and back, and a stalled output
//  holds the whole cell pipeline; the front keeps taking words until full
//  rst is synchronous; settings return to 5, -4, 10, 1 and the row store reads 0
module smith_waterman_affine_with_direction #(
  parameter int MAX_QUERY  = swaff_pkg::MAX_QUERY_DEF,
  parameter int SCORE_BITS = swaff_pkg::SCORE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [1:0]                     base,
  input  logic [swaff_pkg::POS_BITS-1:0] position,
  input  logic                           new_alignment,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [swaff_pkg::POS_BITS-1:0] query_index,
  output logic [swaff_pkg::CAP_BITS-1:0] cell_score,
  output logic [2:0]                     direction_code,
  output logic [swaff_pkg::CAP_BITS-1:0] best_score,
  output logic                           row_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [7:0]                     cfg_data
);

  swaff_pkg::cfg_t  cfg;
  logic             q_valid;
  logic             q_pop;
  swaff_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match       <= 7'd5;
      cfg.mismatch    <= 8'hFC;
      cfg.open_cost   <= 8'd10;
      cfg.extend_cost <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swaff_pkg::CFG_MATCH:    cfg.match       <= cfg_data[6:0];
        swaff_pkg::CFG_MISMATCH: cfg.mismatch    <= cfg_data;
        swaff_pkg::CFG_OPEN:     cfg.open_cost   <= cfg_data;
        swaff_pkg::CFG_EXTEND:   cfg.extend_cost <= cfg_data;
      endcase
    end
  end

  swaff_front #(
    .MAX_QUERY (MAX_QUERY)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .base          (base),
    .position      (position),
    .new_alignment (new_alignment),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  swaff_back #(
    .MAX_QUERY  (MAX_QUERY),
    .SCORE_BITS (SCORE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .query_index    (query_index),
    .cell_score     (cell_score),
    .direction_code (direction_code),
    .best_score     (best_score),
    .row_last       (row_last)
  );

endmodule

// File: verif/swaff_cell_checker.sv
// cell checker: mirrors the affine-gap row fill and compares every output word
`timescale 1ns / 1ps

module swaff_cell_checker
  import swaff_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                req_type,
  input  logic [1:0]          base,
  input  logic [POS_BITS-1:0] position,
  input  logic                new_alignment,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [POS_BITS-1:0] query_index,
  input  logic [CAP_BITS-1:0] cell_score,
  input  logic [2:0]          direction_code,
  input  logic [CAP_BITS-1:0] best_score,
  input  logic                row_last,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  cells_pending
);

  localparam int SCORE_HI = (1 << (SCORE_BITS_DEF - 1)) - 1;
  localparam int SCORE_LO = -SCORE_HI - 1;

  typedef struct packed {
    logic [POS_BITS-1:0] idx;
    logic [CAP_BITS-1:0] score;
    logic [2:0]          dir;
    logic [CAP_BITS-1:0] best;
    logic                last;
  } cell_t;

  logic [1:0]        query_bases [ROW_CAP];
  int                query_len;
  int                row_h       [ROW_CAP];
  int                row_f       [ROW_CAP];
  int                best_cell;
  logic [6:0]        w_match;
  logic signed [7:0] w_mismatch;
  logic [7:0]        w_open;
  logic [7:0]        w_extend;
  cell_t             cells_due [$];
  int                shown;

  function automatic int clamp_score(input int v);
    if (v > SCORE_HI) return SCORE_HI;
    if (v < SCORE_LO) return SCORE_LO;
    return v;
  endfunction

  function automatic int max_of(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // one reference base against the whole stored query
  task automatic fill_row(input logic [1:0] ref_base, input logic first_row);
    int    j;
    int    hleft, gap_e, hdiag, subst, hup, d, f, mde, mfz, h, hout, opn, ext;
    cell_t c;
    if (first_row) begin
      for (j = 0; j < ROW_CAP; j++) begin
        row_h[j] = 0;
        row_f[j] = 0;
      end
      best_cell = 0;
    end
    opn   = int'(w_open);
    ext   = int'(w_extend);
    hleft = 0;
    gap_e = 0;
    hdiag = 0;
    for (j = 0; j < query_len; j++) begin
      subst = (query_bases[j] == ref_base) ? int'(w_match) : int'(w_mismatch);
      hup   = row_h[j];
      gap_e = max_of(clamp_score(gap_e - ext), clamp_score(hleft - opn));
      d     = clamp_score(hdiag + subst);
      f     = max_of(clamp_score(row_f[j] - ext), clamp_score(hup - opn));
      mde   = max_of(d, gap_e);
      mfz   = max_of(f, 0);
      h     = max_of(mde, mfz);
      hdiag = hup;
      hleft = h;
      row_h[j] = h;
      row_f[j] = f;
      hout = (h > OUT_CAP) ? OUT_CAP : h;
      if (hout > best_cell) best_cell = hout;
      c.idx   = POS_BITS'(j);
      c.score = CAP_BITS'(hout);
      c.dir   = {(d >= gap_e), (f >= 0), (mde >= mfz)};
      c.best  = CAP_BITS'(best_cell);
      c.last  = (j + 1 == query_len);
      cells_due.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    cell_t got, exp_c;
    if (rst) begin
      query_len  = 0;
      best_cell  = 0;
      for (int j = 0; j < ROW_CAP; j++) begin
        row_h[j] = 0;
        row_f[j] = 0;
      end
      w_match    = 7'd5;
      w_mismatch = -8'sd4;
      w_open     = 8'd10;
      w_extend   = 8'd1;
      cells_due.delete();
      fail_count = 0;
      shown      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MATCH:    w_match    = cfg_data[6:0];
          CFG_MISMATCH: w_mismatch = cfg_data;
          CFG_OPEN:     w_open     = cfg_data;
          CFG_EXTEND:   w_extend   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_LOAD) begin
          query_bases[position] = base;
          query_len = int'(position) + 1;
        end else begin
          fill_row(base, new_alignment);
        end
      end
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got = '{query_index, cell_score, direction_code, best_score, row_last};
        if (cells_due.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("%0t: unexpected cell word idx %0d score %0d dir %0d best %0d last %0d",
                     $time, got.idx, got.score, got.dir, got.best, got.last);
          end
        end else begin
          exp_c = cells_due.pop_front();
          if (got.idx !== exp_c.idx || got.score !== exp_c.score || got.dir !== exp_c.dir ||
              got.best !== exp_c.best || got.last !== exp_c.last) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("%0t: cell mismatch exp idx %0d score %0d dir %0d best %0d last %0d",
                       $time, exp_c.idx, exp_c.score, exp_c.dir, exp_c.best, exp_c.last);
              $display("%0t:               got idx %0d score %0d dir %0d best %0d last %0d",
                       $time, got.idx, got.score, got.dir, got.best, got.last);
            end
          end
        end
      end
    end
    cells_pending = cells_due.size();
  end

endmodule

// File: verif/tb_top.sv
// testbench top: stimulus, settings phases, output stalls and verdict
`timescale 1ns / 1ps

module tb_top;
  import swaff_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_WORDS   = 30;
  localparam int PRESS_ROWS    = 8;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                req_type;
  logic [1:0]          base;
  logic [POS_BITS-1:0] position;
  logic                new_alignment;
  logic                out_valid;
  logic                out_stall;
  logic [POS_BITS-1:0] query_index;
  logic [CAP_BITS-1:0] cell_score;
  logic [2:0]          direction_code;
  logic [CAP_BITS-1:0] best_score;
  logic                row_last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [7:0]          cfg_data;

  int fail_count;
  int cells_pending;
  int cycle_count;
  int words_sent;
  int loaded_upto;   // positions below this have been loaded since reset
  bit steady;        // no idling on either side
  int hold_asks;
  int hold_done;
  int hold_left;

  smith_waterman_affine_with_direction u_top (.*);

  swaff_cell_checker u_cell_chk (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_asks != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 32);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic rt, input logic [1:0] b, input int p, input logic na);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rt;
    base          <= b;
    position      <= POS_BITS'(p);
    new_alignment <= na;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (rt == REQ_LOAD && p == loaded_upto) loaded_upto++;
  endtask

  task automatic load_query(input int len);
    int p;
    for (p = 0; p < len; p++) begin
      send_word(REQ_LOAD, 2'($urandom_range(3)), p, 1'($urandom_range(1)));
    end
  endtask

  task automatic run_rows(input int rows, input logic first_new);
    int k;
    for (k = 0; k < rows; k++) begin
      send_word(REQ_ROW, 2'($urandom_range(3)), $urandom_range(63),
                (k == 0) ? first_new : 1'b0);
    end
  endtask

  // drop valid, wait for every cell word, then let the back end go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (cells_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(input logic [7:0] m, input logic [7:0] mm,
                                input logic [7:0] o, input logic [7:0] e);
    logic [7:0] vals [4];
    vals[CFG_MATCH]    = m;
    vals[CFG_MISMATCH] = mm;
    vals[CFG_OPEN]     = o;
    vals[CFG_EXTEND]   = e;
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int quota, input bit go_long);
    int stop_at, r, len, k;
    stop_at = words_sent + quota;
    if (go_long) begin
      load_query(ROW_CAP);
      run_rows($urandom_range(1, 3), 1'b1);
    end
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 60) begin
        // fresh query, then a short run of rows
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
        load_query(len);
        run_rows($urandom_range(1, 6), 1'b1);
      end else if (r < 80) begin
        run_rows($urandom_range(1, 4), ($urandom_range(3) == 0));
      end else begin
        // stray loads at legal positions, may shrink the query
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          send_word(REQ_LOAD, 2'($urandom_range(3)),
                    $urandom_range(0, (loaded_upto > 63) ? 63 : loaded_upto),
                    1'($urandom_range(1)));
        end
        run_rows($urandom_range(1, 2), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = REQ_LOAD;
    base          = 2'd0;
    position      = '0;
    new_alignment = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_MATCH;
    cfg_data      = 8'd0;
    steady        = 1'b0;
    hold_asks     = 0;
    words_sent    = 0;
    loaded_upto   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty query, with and without the first-row clear
    send_word(REQ_ROW, 2'd2, 0, 1'b1);
    send_word(REQ_ROW, 2'd1, 63, 1'b0);
    // every base code; new_alignment on a load is ignored
    send_word(REQ_LOAD, 2'd0, 0, 1'b1);
    send_word(REQ_LOAD, 2'd1, 1, 1'b0);
    send_word(REQ_LOAD, 2'd2, 2, 1'b1);
    send_word(REQ_LOAD, 2'd3, 3, 1'b0);
    send_word(REQ_ROW, 2'd0, 0, 1'b1);
    send_word(REQ_ROW, 2'd1, 0, 1'b0);
    send_word(REQ_ROW, 2'd2, 0, 1'b0);
    send_word(REQ_ROW, 2'd3, 0, 1'b0);
    // shrink the query, then grow it back by one
    send_word(REQ_LOAD, 2'd3, 1, 1'b0);
    send_word(REQ_ROW, 2'd3, 0, 1'b0);
    send_word(REQ_LOAD, 2'd0, 2, 1'b0);
    send_word(REQ_ROW, 2'd0, 0, 1'b0);
    send_word(REQ_LOAD, 2'd3, 3, 1'b0);
    send_word(REQ_LOAD, 2'd2, 4, 1'b0);
    send_word(REQ_LOAD, 2'd1, 5, 1'b0);
    send_word(REQ_LOAD, 2'd0, 6, 1'b0);
    send_word(REQ_ROW, 2'd2, 0, 1'b1);
    send_word(REQ_ROW, 2'd3, 0, 1'b0);
    send_word(REQ_ROW, 2'd0, 0, 1'b0);
    random_phase(PHASE_WORDS, 1'b0);
    settle();

    write_settings(8'd127, 8'h80, 8'd0, 8'd0);
    random_phase(PHASE_WORDS, 1'b1);
    settle();

    write_settings(8'd0, 8'h00, 8'd255, 8'd255);
    random_phase(PHASE_WORDS, 1'b0);
    settle();

    steady <= 1'b1;
    write_settings(8'($urandom_range(127)), 8'(-$urandom_range(128)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    random_phase(PHASE_WORDS, 1'b0);
    settle();
    steady <= 1'b0;

    // long output hold-off so the queue fills and the input stalls
    hold_asks <= hold_asks + 1;
    write_settings(8'd127, 8'h00, 8'd255, 8'd0);
    load_query(ROW_CAP);
    run_rows(PRESS_ROWS, 1'b1);
    settle();

    write_settings(8'($urandom_range(127)), 8'(-$urandom_range(128)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    random_phase(PHASE_WORDS, 1'b0);
    settle();

    write_settings(8'd5, 8'hFC, 8'd10, 8'd1);
    random_phase(PHASE_WORDS / 2, 1'b0);
    settle();

    if (fail_count == 0 && cells_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/swaff_pkg.sv
hw/rtl/swaff_front.sv
hw/rtl/swaff_back.sv
hw/rtl/smith_waterman_affine_with_direction.sv
verif/swaff_cell_checker.sv
verif/tb_top.sv
